@@ rtl/hsl2rgb_pkg.sv @@
// hsl2rgb_pkg: types and fixed-point constants for the hsl to rgb converter
// no dependencies; imported by hsl_to_rgb_convert_core
`timescale 1ns / 1ps

package hsl2rgb_pkg;

    // 60-degree hue sectors, named by the colours at their ends
    typedef enum logic [2:0] {
        SEC_RED_YELLOW,
        SEC_YELLOW_GREEN,
        SEC_GREEN_CYAN,
        SEC_CYAN_BLUE,
        SEC_BLUE_MAGENTA,
        SEC_MAGENTA_RED
    } sector_t;

    localparam int unsigned HUE_W   = 9;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned AS_W    = 14;  // a*s up to 10000
    localparam int unsigned NUM_W   = 20;  // numerators over 600000
    localparam int unsigned SUM_W   = 21;
    localparam int unsigned SCL_W   = 25;  // sum*17
    localparam int unsigned Y_W     = 19;  // sum*17/64
    localparam int unsigned RCP_W   = 20;
    localparam int unsigned PROD_W  = Y_W + RCP_W;
    localparam int unsigned Q_SHIFT = 29;
    localparam int unsigned Q_W     = PROD_W - Q_SHIFT;

    localparam logic [HUE_W-1:0] HUE_WRAP  = 9'd360;
    localparam logic [HUE_W-1:0] HUE_60    = 9'd60;
    localparam logic [HUE_W-1:0] HUE_120   = 9'd120;
    localparam logic [HUE_W-1:0] HUE_180   = 9'd180;
    localparam logic [HUE_W-1:0] HUE_240   = 9'd240;
    localparam logic [HUE_W-1:0] HUE_300   = 9'd300;

    localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
    localparam logic [PCT_W-1:0] PCT_HALF  = 7'd50;
    localparam logic [PCT_W:0]   PCT_TWICE = 8'd200;

    localparam logic [NUM_W-1:0] CHROMA_MUL = 20'd60;
    localparam logic [NUM_W-1:0] LIGHT_MUL  = 20'd6000;
    localparam logic [NUM_W-1:0] HALF_C_MUL = 20'd30;

    // 255/600000 = 17/40000 = 17/(64*625)
    localparam logic [SCL_W-1:0] SCALE_NUM  = 25'd17;
    localparam int unsigned      SCALE_SHR  = 6;
    // ceil(2^29/625), exact for every 19-bit dividend
    localparam logic [RCP_W-1:0] RECIP_625  = 20'd858994;

    localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'hFF;

endpackage

@@ rtl/hsl_to_rgb_convert_core.sv @@
// hsl_to_rgb_convert_core: pipelined hsl to rgb colour converter, top level
// depends on hsl2rgb_pkg for sector codes and fixed-point constants
`timescale 1ns / 1ps

// usage
//   input stream s_*: one colour per transfer, hue in degrees (wrapped modulo 360
//   when 360 or above), saturation and lightness in percent (clamped at 100)
//   output stream m_*: one 8-bit red, green, blue triple per input transfer,
//   in the same order, each channel truncated toward zero
//   throughput: one colour per clock; the five-stage pipeline takes a new item
//   every cycle while the receiver keeps m_tready high
//   stages: clamp/sector, a*s product, chroma/secondary/offset numerators,
//   channel select and scale by 17/64, reciprocal multiply by 1/625 with clamp
//   stall: when m_tready is low with a result waiting, the whole pipeline holds
//   and s_tready drops; no item is lost or repeated, and empty slots stay
//   where they are until the result is taken
//   reset: aresetn (synchronous, active low) clears all stage valid bits;
//   payload registers are left as they are
module hsl_to_rgb_convert_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [8:0] hue, [15:9] saturation, [22:16] lightness
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [7:0] red, [15:8] green, [23:16] blue
);
    import hsl2rgb_pkg::*;

    // pipeline advance: last stage empty or being taken
    logic pipe_en;

    // input fields
    logic [HUE_W-1:0] hue_in;
    logic [PCT_W-1:0] sat_in;
    logic [PCT_W-1:0] lgt_in;

    // stage 1 combinational
    logic [HUE_W-1:0] hue_w;
    logic [PCT_W-1:0] sat_c;
    logic [PCT_W-1:0] lgt_c;
    logic [HUE_W-1:0] hue_base;
    logic [PCT_W-1:0] hue_mod;
    sector_t          sec_next;
    logic [5:0]       b_next;
    logic [PCT_W-1:0] a_next;

    // stage registers
    logic             v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    sector_t          sec1_reg, sec2_reg, sec3_reg;
    logic [5:0]       b1_reg, b2_reg;
    logic [PCT_W-1:0] a1_reg, s1_reg, l1_reg, l2_reg;
    logic [AS_W-1:0]  as2_reg;
    logic [NUM_W-1:0] cn3_reg, xn3_reg, mn3_reg;
    logic [Y_W-1:0]   y4_reg [3];
    logic [CHAN_W-1:0] chan5_reg [3];

    // stage 4 and 5 combinational, one lane per channel (red, green, blue)
    logic [NUM_W-1:0]  comp [3];
    logic [SUM_W-1:0]  sum  [3];
    logic [SCL_W-1:0]  scl  [3];
    logic [Y_W-1:0]    y_next [3];
    logic [PROD_W-1:0] prod [3];
    logic [Q_W-1:0]    quo  [3];
    logic [CHAN_W-1:0] chan_next [3];

    assign pipe_en  = !v5_reg || m_tready;
    assign s_tready = pipe_en;
    assign m_tvalid = v5_reg;
    assign m_tdata  = {chan5_reg[2], chan5_reg[1], chan5_reg[0]};

    assign hue_in = s_tdata[8:0];
    assign sat_in = s_tdata[15:9];
    assign lgt_in = s_tdata[22:16];

    // stage 1: wrap and clamp, hue sector, distance term b, lightness term a
    always_comb begin
        hue_w = (hue_in >= HUE_WRAP) ? (hue_in - HUE_WRAP) : hue_in;
        sat_c = (sat_in > PCT_MAX) ? PCT_MAX : sat_in;
        lgt_c = (lgt_in > PCT_MAX) ? PCT_MAX : lgt_in;

        priority if (hue_w >= HUE_300) begin
            sec_next = SEC_MAGENTA_RED;
        end else if (hue_w >= HUE_240) begin
            sec_next = SEC_BLUE_MAGENTA;
        end else if (hue_w >= HUE_180) begin
            sec_next = SEC_CYAN_BLUE;
        end else if (hue_w >= HUE_120) begin
            sec_next = SEC_GREEN_CYAN;
        end else if (hue_w >= HUE_60) begin
            sec_next = SEC_YELLOW_GREEN;
        end else begin
            sec_next = SEC_RED_YELLOW;
        end

        // hue modulo 120
        priority if (hue_w >= HUE_240) begin
            hue_base = HUE_240;
        end else if (hue_w >= HUE_120) begin
            hue_base = HUE_120;
        end else begin
            hue_base = '0;
        end
        hue_mod = PCT_W'(hue_w - hue_base);
        b_next  = (hue_mod >= PCT_W'(HUE_60)) ? 6'(PCT_W'(HUE_120) - hue_mod)
                                              : 6'(hue_mod);

        a_next = (lgt_c >= PCT_HALF) ? PCT_W'(PCT_TWICE - {lgt_c, 1'b0})
                                     : PCT_W'({lgt_c, 1'b0});
    end

    // stages 4 and 5 per channel
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            comp[i] = '0;
        end
        unique case (sec3_reg)
            SEC_RED_YELLOW: begin
                comp[0] = cn3_reg; comp[1] = xn3_reg;
            end
            SEC_YELLOW_GREEN: begin
                comp[0] = xn3_reg; comp[1] = cn3_reg;
            end
            SEC_GREEN_CYAN: begin
                comp[1] = cn3_reg; comp[2] = xn3_reg;
            end
            SEC_CYAN_BLUE: begin
                comp[1] = xn3_reg; comp[2] = cn3_reg;
            end
            SEC_BLUE_MAGENTA: begin
                comp[0] = xn3_reg; comp[2] = cn3_reg;
            end
            default: begin
                comp[0] = cn3_reg; comp[2] = xn3_reg;
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            sum[i]       = SUM_W'(comp[i]) + SUM_W'(mn3_reg);
            scl[i]       = SCL_W'(sum[i]) * SCALE_NUM;
            y_next[i]    = scl[i][SCL_W-1:SCALE_SHR];
            prod[i]      = PROD_W'(y4_reg[i]) * PROD_W'(RECIP_625);
            quo[i]       = prod[i][PROD_W-1:Q_SHIFT];
            chan_next[i] = (quo[i] > Q_W'(CHAN_MAX)) ? CHAN_MAX : quo[i][CHAN_W-1:0];
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            // stage 1
            sec1_reg <= sec_next;
            b1_reg   <= b_next;
            a1_reg   <= a_next;
            s1_reg   <= sat_c;
            l1_reg   <= lgt_c;
            // stage 2: a*s
            as2_reg  <= AS_W'(a1_reg) * AS_W'(s1_reg);
            b2_reg   <= b1_reg;
            l2_reg   <= l1_reg;
            sec2_reg <= sec1_reg;
            // stage 3: chroma, secondary and offset numerators over 600000
            cn3_reg  <= NUM_W'(as2_reg) * CHROMA_MUL;
            xn3_reg  <= NUM_W'(as2_reg) * NUM_W'(b2_reg);
            mn3_reg  <= NUM_W'(l2_reg) * LIGHT_MUL - NUM_W'(as2_reg) * HALF_C_MUL;
            sec3_reg <= sec2_reg;
            // stages 4 and 5
            for (int i = 0; i < 3; i++) begin
                y4_reg[i]    <= y_next[i];
                chan5_reg[i] <= chan_next[i];
            end
        end
    end

endmodule

@@ tb/hsl_rgb_checker.sv @@
// hsl_rgb_checker: watches both streams of the hsl to rgb converter, predicts each colour
// and compares the red, green and blue fields of every output transfer
// depends on hsl2rgb_pkg for field widths and sector codes
`timescale 1ns / 1ps

module hsl_rgb_checker
    import hsl2rgb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [23:0]       s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [23:0]       m_tdata,
    output int unsigned       colours_in_flight,
    output int unsigned       mismatch_count
);

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    localparam longint unsigned COMMON_DEN = 600000;

    rgb_t rgb_pending[$];

    initial begin
        colours_in_flight = 0;
        mismatch_count    = 0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns  colour check: %s", $time, what);
        mismatch_count++;
    endtask

    // (component + offset) * 255 / D with one truncation at the end
    function automatic logic [CHAN_W-1:0] scale_channel(input int unsigned comp,
                                                        input int unsigned offset);
        longint unsigned level;
        level = ((longint'(comp) + longint'(offset)) * 255) / COMMON_DEN;
        if (level > 255)
            level = 255;
        return level[CHAN_W-1:0];
    endfunction

    function automatic rgb_t rgb_from_hsl(input logic [HUE_W-1:0] hue_in,
                                          input logic [PCT_W-1:0] sat_in,
                                          input logic [PCT_W-1:0] light_in);
        int unsigned hue, sat, light;
        int unsigned a_term, hue_mod, b_term, a_s;
        int unsigned chroma_n, second_n, offset_n;
        int unsigned red_n, green_n, blue_n;
        sector_t     sector;
        rgb_t        rgb;
        hue   = (hue_in >= 360) ? hue_in - 360 : hue_in;
        sat   = (sat_in > 100) ? 100 : sat_in;
        light = (light_in > 100) ? 100 : light_in;

        a_term  = (light >= 50) ? 200 - 2 * light : 2 * light;
        hue_mod = hue % 120;
        b_term  = (hue_mod >= 60) ? 120 - hue_mod : hue_mod;

        a_s      = a_term * sat;
        chroma_n = 60 * a_s;
        second_n = a_s * b_term;
        offset_n = 6000 * light - 30 * a_s;

        sector = sector_t'(hue / 60);
        case (sector)
            SEC_RED_YELLOW: begin
                red_n = chroma_n; green_n = second_n; blue_n = 0;
            end
            SEC_YELLOW_GREEN: begin
                red_n = second_n; green_n = chroma_n; blue_n = 0;
            end
            SEC_GREEN_CYAN: begin
                red_n = 0; green_n = chroma_n; blue_n = second_n;
            end
            SEC_CYAN_BLUE: begin
                red_n = 0; green_n = second_n; blue_n = chroma_n;
            end
            SEC_BLUE_MAGENTA: begin
                red_n = second_n; green_n = 0; blue_n = chroma_n;
            end
            default: begin
                red_n = chroma_n; green_n = 0; blue_n = second_n;
            end
        endcase

        rgb.red   = scale_channel(red_n, offset_n);
        rgb.green = scale_channel(green_n, offset_n);
        rgb.blue  = scale_channel(blue_n, offset_n);
        return rgb;
    endfunction

    always @(posedge aclk) begin
        rgb_t got;
        rgb_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                rgb_pending.push_back(rgb_from_hsl(s_tdata[8:0], s_tdata[15:9],
                                                   s_tdata[22:16]));
            if (m_tvalid && m_tready) begin
                got.red   = m_tdata[7:0];
                got.green = m_tdata[15:8];
                got.blue  = m_tdata[23:16];
                if (rgb_pending.size() == 0) begin
                    report_mismatch($sformatf("unexpected output r=%0d g=%0d b=%0d",
                                              got.red, got.green, got.blue));
                end else begin
                    want = rgb_pending.pop_front();
                    if (got.red !== want.red)
                        report_mismatch($sformatf("red %0d, predicted %0d",
                                                  got.red, want.red));
                    if (got.green !== want.green)
                        report_mismatch($sformatf("green %0d, predicted %0d",
                                                  got.green, want.green));
                    if (got.blue !== want.blue)
                        report_mismatch($sformatf("blue %0d, predicted %0d",
                                                  got.blue, want.blue));
                end
            end
        end
        colours_in_flight <= rgb_pending.size();
    end

endmodule

@@ tb/tb_top.sv @@
// tb_top: stimulus and verdict for hsl_to_rgb_convert_core
// depends on the rtl core, hsl2rgb_pkg and the hsl_rgb_checker module
`timescale 1ns / 1ps

module tb_top;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // [8:0] hue, [15:9] saturation, [22:16] lightness
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [7:0] red, [15:8] green, [23:16] blue

    // idling on both streams; switched off for one long stretch of the random part
    logic        idle_on  = 1'b1;

    int unsigned colours_in_flight;
    int unsigned mismatch_count;

    hsl_to_rgb_convert_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    hsl_rgb_checker colour_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .colours_in_flight (colours_in_flight),
        .mismatch_count    (mismatch_count)
    );

    // 125 MHz clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // hard limit, far above the slowest correct run
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver back-pressure, ready held off about 30 percent of the time while idling is on
    always @(posedge aclk) begin
        m_tready <= !idle_on || ($urandom_range(99) >= 30);
    end

    // one colour transfer; random gaps with tvalid low before it while idling is on
    task automatic send_colour(input logic [8:0] hue, input logic [6:0] sat,
                               input logic [6:0] light);
        while (idle_on && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, light, sat, hue};
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending and let the pipeline empty completely
    task automatic drain_pipeline;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (colours_in_flight != 0)
            @(posedge aclk);
    endtask

    initial begin
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] light;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: black, white, pure red and every sector edge
        send_colour(9'd0,   7'd0,   7'd0);
        send_colour(9'd0,   7'd100, 7'd100);
        send_colour(9'd0,   7'd100, 7'd50);
        send_colour(9'd59,  7'd100, 7'd50);
        send_colour(9'd60,  7'd100, 7'd50);
        send_colour(9'd119, 7'd100, 7'd50);
        send_colour(9'd120, 7'd100, 7'd50);
        send_colour(9'd180, 7'd100, 7'd50);
        send_colour(9'd240, 7'd100, 7'd50);
        send_colour(9'd300, 7'd100, 7'd50);
        send_colour(9'd359, 7'd100, 7'd50);
        // hue wrap at 360 and at the top of the field
        send_colour(9'd360, 7'd100, 7'd50);
        send_colour(9'd511, 7'd100, 7'd50);
        // saturation and lightness clamps
        send_colour(9'd30,  7'd101, 7'd50);
        send_colour(9'd30,  7'd127, 7'd50);
        send_colour(9'd90,  7'd100, 7'd101);
        send_colour(9'd90,  7'd100, 7'd127);
        // either side of the lightness fold at 50
        send_colour(9'd200, 7'd50,  7'd49);
        send_colour(9'd200, 7'd50,  7'd51);
        send_colour(9'd330, 7'd1,   7'd1);
        send_colour(9'd45,  7'd99,  7'd99);
        send_colour(9'd511, 7'd127, 7'd127);
        send_colour(9'd150, 7'd0,   7'd75);

        drain_pipeline();

        // random colours, mostly legal, some beyond range to exercise wrap and clamp
        for (int i = 0; i < 1000; i++) begin
            if (i == 300)
                idle_on <= 1'b0;
            if (i == 550)
                idle_on <= 1'b1;
            if (i == 700)
                drain_pipeline();
            hue   = ($urandom_range(99) < 15) ? 9'($urandom_range(511))
                                              : 9'($urandom_range(359));
            sat   = ($urandom_range(99) < 15) ? 7'($urandom_range(127))
                                              : 7'($urandom_range(100));
            light = ($urandom_range(99) < 15) ? 7'($urandom_range(127))
                                              : 7'($urandom_range(100));
            send_colour(hue, sat, light);
        end

        drain_pipeline();
        // five-stage pipeline: allow stray outputs time to show up
        repeat (16) @(posedge aclk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
